// ----- design/stx_etx_frame_checker_defines.svh -----
// Assertion macros used by the frame checker top level.
`ifndef STX_ETX_FRAME_CHECKER_DEFINES_SVH
`define STX_ETX_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, quiet while reset is held.
`define SEFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is held.
`define SEFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sefc_pkg.sv -----
// Shared types and constants for the STX/ETX frame checker.
`timescale 1ns / 1ps
`default_nettype none

package sefc_pkg;

    // Recognized command bytes
    localparam logic [7:0] CMD_READ_FW     = 8'h51;
    localparam logic [7:0] CMD_READ_STATUS = 8'h52;

    // Reset values of the configuration registers
    localparam logic [7:0] START_BYTE_RST   = 8'h02;
    localparam logic [7:0] END_BYTE_RST     = 8'h03;
    localparam logic [8:0] MIN_FRAME_RST    = 9'd5;
    localparam logic [7:0] UNKNOWN_CODE_RST = 8'hFF;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 9;
    localparam int OUT_DATA_W  = 24;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_START_BYTE   = 2'd0,
        CFG_END_BYTE     = 2'd1,
        CFG_MIN_FRAME    = 2'd2,
        CFG_UNKNOWN_CODE = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        CID_UNKNOWN     = 2'd0,
        CID_READ_FW     = 2'd1,
        CID_READ_STATUS = 2'd2
    } cid_t;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_SHORT     = 3'd1,
        VERDICT_BAD_START = 3'd2,
        VERDICT_BAD_END   = 3'd3,
        VERDICT_SIZE      = 3'd4,
        VERDICT_CHECKSUM  = 3'd5
    } verdict_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    // One queued result item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] payload_byte;
        cid_t       command_id;
        verdict_t   verdict;
        logic [7:0] payload_count;
    } entry_t;

    // Queue fill status seen by the front and the back
    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } qstat_t;

endpackage

`default_nettype wire

// ----- design/sefc_front.sv -----
// Front end: accepts frame bytes, tracks frame state, emits payload and status items.
`timescale 1ns / 1ps
`default_nettype none

module sefc_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,
    input  wire logic                             s_tlast,
    input  wire logic                             cfg_we,
    input  wire logic [sefc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sefc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire sefc_pkg::qstat_t                 qstat,
    output logic                                  push,
    output sefc_pkg::entry_t                      push_entry
);
    import sefc_pkg::*;

    // Configuration registers
    logic [7:0] start_byte_reg;
    logic [7:0] end_byte_reg;
    logic [8:0] min_frame_reg;
    logic [7:0] unknown_code_reg;

    // Per-frame state
    logic [8:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] chk_reg, chk_next;
    logic       sm_reg, sm_next;

    logic       accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg   <= START_BYTE_RST;
            end_byte_reg     <= END_BYTE_RST;
            min_frame_reg    <= MIN_FRAME_RST;
            unknown_code_reg <= UNKNOWN_CODE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_START_BYTE:   start_byte_reg   <= cfg_data[7:0];
                CFG_END_BYTE:     end_byte_reg     <= cfg_data[7:0];
                CFG_MIN_FRAME:    min_frame_reg    <= cfg_data;
                CFG_UNKNOWN_CODE: unknown_code_reg <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    assign s_tready = !qstat.full;
    assign accept   = s_tvalid && s_tready;

    // Classify the byte and compute the next frame state
    always_comb
    begin
        logic       in_payload;
        logic [7:0] len_eff;
        logic [7:0] cmd_eff;
        logic       sm_eff;
        logic [8:0] len_p1;
        logic [8:0] len_p2;
        logic [9:0] total;
        logic [9:0] len_p4;
        logic [8:0] pos_m1;
        logic [8:0] top;
        logic [8:0] count;
        logic [7:0] code;
        cid_t       cid;
        verdict_t   verdict;

        pos_next = pos_reg;
        len_next = len_reg;
        cmd_next = cmd_reg;
        sum_next = sum_reg;
        chk_next = chk_reg;
        sm_next  = sm_reg;
        push     = 1'b0;
        push_entry = '{kind: KIND_PAYLOAD, payload_byte: 8'd0, command_id: CID_UNKNOWN,
                       verdict: VERDICT_OK, payload_count: 8'd0};

        len_p1     = {1'b0, len_reg} + 9'd1;
        len_p2     = {1'b0, len_reg} + 9'd2;
        in_payload = (pos_reg >= 9'd3) && (pos_reg <= len_p1);

        // Header fields take effect on the byte that carries them
        len_eff = (pos_reg == 9'd1) ? s_tdata : len_reg;
        cmd_eff = (pos_reg == 9'd2) ? s_tdata : cmd_reg;
        sm_eff  = (pos_reg == 9'd0) ? (s_tdata == start_byte_reg) : sm_reg;

        // Status fields
        total  = {1'b0, pos_reg} + 10'd1;
        len_p4 = {2'b0, len_eff} + 10'd4;
        pos_m1 = pos_reg - 9'd1;
        top    = {1'b0, len_eff} + 9'd1;
        if (pos_reg != 9'd0 && pos_m1 < top)
            top = pos_m1;
        count = (top >= 9'd3) ? (top - 9'd2) : 9'd0;

        if (cmd_eff == CMD_READ_FW)
        begin
            cid  = CID_READ_FW;
            code = CMD_READ_FW;
        end
        else if (cmd_eff == CMD_READ_STATUS)
        begin
            cid  = CID_READ_STATUS;
            code = CMD_READ_STATUS;
        end
        else
        begin
            cid  = CID_UNKNOWN;
            code = unknown_code_reg;
        end

        if (total < {1'b0, min_frame_reg})
            verdict = VERDICT_SHORT;
        else if (!sm_eff)
            verdict = VERDICT_BAD_START;
        else if (s_tdata != end_byte_reg)
            verdict = VERDICT_BAD_END;
        else if (len_eff == 8'd0 || total != len_p4)
            verdict = VERDICT_SIZE;
        else if (code + sum_reg != chk_reg)
            verdict = VERDICT_CHECKSUM;
        else
            verdict = VERDICT_OK;

        if (accept)
        begin
            if (s_tlast)
            begin
                // End of frame: report and clear
                push = 1'b1;
                push_entry = '{kind: KIND_STATUS, payload_byte: 8'd0, command_id: cid,
                               verdict: verdict, payload_count: count[7:0]};
                pos_next = 9'd0;
                len_next = 8'd0;
                cmd_next = 8'd0;
                sum_next = 8'd0;
                chk_next = 8'd0;
                sm_next  = 1'b0;
            end
            else
            begin
                len_next = len_eff;
                cmd_next = cmd_eff;
                sm_next  = sm_eff;
                if (pos_reg >= 9'd3 && pos_reg == len_p2)
                    chk_next = s_tdata;
                if (in_payload)
                begin
                    sum_next = sum_reg + s_tdata;
                    push     = 1'b1;
                    push_entry.payload_byte = s_tdata;
                end
                if (pos_reg != 9'h1FF)
                    pos_next = pos_reg + 9'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 9'd0;
            len_reg <= 8'd0;
            cmd_reg <= 8'd0;
            sum_reg <= 8'd0;
            chk_reg <= 8'd0;
            sm_reg  <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
            cmd_reg <= cmd_next;
            sum_reg <= sum_next;
            chk_reg <= chk_next;
            sm_reg  <= sm_next;
        end
    end

endmodule

`default_nettype wire

// ----- design/sefc_queue.sv -----
// Small FIFO of result items between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module sefc_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire sefc_pkg::entry_t push_entry,
    input  wire logic             pop,
    output sefc_pkg::entry_t      head,
    output sefc_pkg::qstat_t      qstat
);
    import sefc_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push;
    logic                do_pop;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign qstat.count = count_reg;
    assign head        = mem_reg[rd_ptr_reg];

    assign do_push = push && !qstat.full;
    assign do_pop  = pop && !qstat.empty;

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// ----- design/sefc_back.sv -----
// Back end: output register that drains the queue onto the result stream.
`timescale 1ns / 1ps
`default_nettype none

module sefc_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sefc_pkg::entry_t                head,
    input  wire sefc_pkg::qstat_t                qstat,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [sefc_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tuser
);
    import sefc_pkg::*;

    entry_t out_reg;
    logic   valid_reg, valid_next;

    // Load whenever the output slot is free or being emptied
    assign pop        = !qstat.empty && (!valid_reg || m_tready);
    assign valid_next = pop || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            out_reg <= head;
    end

    // Pack fields, highest first
    assign m_tvalid = valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {3'b000, out_reg.payload_count, out_reg.verdict,
                       out_reg.command_id, out_reg.payload_byte};

endmodule

`default_nettype wire

// ----- design/stx_etx_frame_checker.sv -----
// Top level of the STX/ETX length-framed packet checker.
//
// Input stream: one frame byte per item in s_tdata, s_tlast on the final
// byte. Output stream: one item per payload byte (m_tuser = 0) and one
// status item per frame on its last byte (m_tuser = 1) with the command id,
// verdict and payload count. Frame layout: start, length, command, payload,
// checksum, end. Checks in order: short, bad start, bad end, size, checksum.
// Config port: cfg_we with cfg_index 0 start byte, 1 end byte, 2 minimum
// frame size, 3 code summed for unknown commands; write only while idle.
// Throughput: one byte per cycle while the queue is not full. Path: the
// front classifies an accepted byte combinationally and writes its result
// item into a 4-entry queue; one output register follows and drives
// m_tvalid when the output is free.
// Stall: a stalled receiver holds the output register; the queue absorbs up
// to four more result items, then s_tready drops until space frees.
// Reset: frame state clears, config registers return to 02h, 03h, 5, FFh,
// and the queue and output empty.
`timescale 1ns / 1ps
`default_nettype none
`include "stx_etx_frame_checker_defines.svh"

module stx_etx_frame_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // s_tdata: frame_byte[7:0]
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [7:0]                       s_tdata,
    input  wire logic                             s_tlast,
    // m_tdata: payload_byte[7:0], command_id[9:8], verdict[12:10],
    //          payload_count[20:13], zero[23:21]
    // m_tuser: result_kind[0]
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [sefc_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                  m_tuser,
    input  wire logic                             cfg_we,
    input  wire logic [sefc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sefc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import sefc_pkg::*;

    logic   push;
    logic   pop;
    entry_t push_entry;
    entry_t head;
    qstat_t qstat;

    sefc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    sefc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    sefc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .qstat    (qstat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Checks
    `SEFC_ASSERT_NOW(a_status_no_payload, m_tvalid && m_tuser, m_tdata[7:0] == 8'd0, "status item carries payload bits")
    `SEFC_ASSERT_NOW(a_payload_no_status, m_tvalid && !m_tuser, m_tdata[23:8] == 16'd0, "payload item carries status bits")
    `SEFC_ASSERT_NEXT(a_drain, !qstat.empty && (!m_tvalid || m_tready), m_tvalid, "queued item not moved to output")
    `SEFC_ASSERT_NOW(a_no_overflow, push, !qstat.full, "item pushed into a full queue")

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// Self-checking testbench for the STX/ETX frame checker.
`timescale 1ns / 1ps

module tb;
    import sefc_pkg::*;

    // Frame damage applied by the stimulus builder
    typedef enum int {
        DMG_NONE,
        DMG_START,
        DMG_END,
        DMG_SUM,
        DMG_LEN,
        DMG_CUT,
        DMG_LONG
    } damage_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } stim_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   m_tuser;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Bytes waiting to be sent, results waiting to come out
    stim_t  byte_q[$];
    entry_t frame_results_q[$];

    // Register copies
    logic [7:0] cfg_start   = START_BYTE_RST;
    logic [7:0] cfg_end     = END_BYTE_RST;
    logic [8:0] cfg_min     = MIN_FRAME_RST;
    logic [7:0] cfg_unknown = UNKNOWN_CODE_RST;

    // Per-frame state of the predictor
    logic [8:0] frm_pos      = '0;
    logic [7:0] frm_len      = '0;
    logic [7:0] frm_cmd      = '0;
    logic [7:0] frm_sum      = '0;
    logic [7:0] frm_rx_sum   = '0;
    logic       frm_start_ok = 1'b0;

    int errors       = 0;
    int bytes_taken  = 0;
    int queued_items = 0;
    int payload_seen = 0;
    int frames_seen  = 0;
    int verdict_hits[6] = '{default: 0};
    int tx_gap   = 0;
    int tx_quiet = 0;
    int rx_stall = 0;
    int rx_quiet = 0;
    bit rx_hold  = 1'b0;

    stx_etx_frame_checker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Guard against a hung run
    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // Idle length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Track one accepted byte and queue the results it causes
    function automatic void decode_byte(input logic [7:0] b, input logic last);
        int p;
        int len;
        int top;
        int total;
        logic [7:0] code;
        entry_t r;
        p = frm_pos;
        if (p == 0) frm_start_ok = (b == cfg_start);
        else if (p == 1) frm_len = b;
        else if (p == 2) frm_cmd = b;
        len = frm_len;
        r = '0;
        if (!last) begin
            if (p >= 3 && p == len + 2) frm_rx_sum = b;
            if (p >= 3 && p <= len + 1) begin
                frm_sum = frm_sum + b;
                r.kind = KIND_PAYLOAD;
                r.payload_byte = b;
                frame_results_q.insert(frame_results_q.size(), r);
            end
            if (frm_pos != 9'd511) frm_pos = frm_pos + 9'd1;
        end
        else begin
            total = p + 1;
            r.kind = KIND_STATUS;
            if (frm_cmd == CMD_READ_FW) begin
                r.command_id = CID_READ_FW;
                code = CMD_READ_FW;
            end
            else if (frm_cmd == CMD_READ_STATUS) begin
                r.command_id = CID_READ_STATUS;
                code = CMD_READ_STATUS;
            end
            else begin
                r.command_id = CID_UNKNOWN;
                code = cfg_unknown;
            end
            if (total < int'(cfg_min)) r.verdict = VERDICT_SHORT;
            else if (!frm_start_ok) r.verdict = VERDICT_BAD_START;
            else if (b != cfg_end) r.verdict = VERDICT_BAD_END;
            else if (len == 0 || total != len + 4) r.verdict = VERDICT_SIZE;
            else if (8'(code + frm_sum) != frm_rx_sum) r.verdict = VERDICT_CHECKSUM;
            else r.verdict = VERDICT_OK;
            // payload positions seen: 3 .. min(length+1, pos-1)
            top = len + 1;
            if (p >= 1 && p - 1 < top) top = p - 1;
            r.payload_count = (top >= 3) ? 8'(top - 2) : 8'd0;
            frame_results_q.insert(frame_results_q.size(), r);
            frm_pos      = '0;
            frm_len      = '0;
            frm_cmd      = '0;
            frm_sum      = '0;
            frm_rx_sum   = '0;
            frm_start_ok = 1'b0;
        end
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    // Input driver
    always @(posedge clk or negedge rst_n)
    begin : drv_p
        stim_t nxt;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            tx_gap = 0;
            tx_quiet = 0;
        end
        else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0 || byte_q.size() == 0) begin
                    s_tvalid <= 1'b0;
                    if (tx_gap > 0) tx_gap--;
                end
                else begin
                    nxt = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.last;
                    if (tx_quiet > 0) begin
                        tx_quiet--;
                        tx_gap = 0;
                    end
                    else begin
                        tx_gap = pick_gap();
                        if ($urandom_range(0, 47) == 0) tx_quiet = $urandom_range(30, 120);
                    end
                end
            end
        end
    end

    // Output monitor and ready generator
    always @(posedge clk or negedge rst_n)
    begin : mon_p
        entry_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
            rx_stall = 0;
            rx_quiet = 0;
        end
        else begin
            if (m_tvalid && m_tready) begin
                if (frame_results_q.size() == 0) begin
                    $error("result with none pending: tuser %0d tdata %h", m_tuser, m_tdata);
                    errors++;
                end
                else begin
                    want = frame_results_q.pop_front();
                    check_field("result_kind", want.kind, m_tuser);
                    check_field("payload_byte", want.payload_byte, m_tdata[7:0]);
                    check_field("command_id", want.command_id, m_tdata[9:8]);
                    check_field("verdict", want.verdict, m_tdata[12:10]);
                    check_field("payload_count", want.payload_count, m_tdata[20:13]);
                    if (want.kind == KIND_STATUS) begin
                        frames_seen++;
                        verdict_hits[want.verdict]++;
                    end
                    else begin
                        payload_seen++;
                    end
                end
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end
            else if (rx_stall > 0) begin
                m_tready <= 1'b0;
                rx_stall--;
            end
            else begin
                m_tready <= 1'b1;
                if (rx_quiet > 0) begin
                    rx_quiet--;
                end
                else if ($urandom_range(0, 3) == 0) begin
                    rx_stall = pick_gap();
                    if ($urandom_range(0, 31) == 0) rx_quiet = $urandom_range(30, 120);
                end
            end
        end
    end

    // Long receiver hold-off while the sender keeps going
    initial
    begin
        while (bytes_taken < 120) @(negedge clk);
        rx_hold = 1'b1;
        repeat (300) @(negedge clk);
        rx_hold = 1'b0;
    end

    task automatic push_byte(input logic [7:0] b, input logic last);
        stim_t s;
        s.data = b;
        s.last = last;
        byte_q.insert(byte_q.size(), s);
        queued_items++;
    endtask

    // Random bytes as one frame, optionally led by the start byte
    task automatic add_noise(input int n, input bit lead);
        for (int i = 0; i < n; i++)
            push_byte((i == 0 && lead) ? cfg_start : 8'($urandom), i == n - 1);
    endtask

    // Well-formed frame with random payload, then the chosen damage
    task automatic add_frame(input int plen, input logic [7:0] cmd, input damage_t dmg);
        logic [7:0] frm[$];
        logic [7:0] sum;
        logic [7:0] b;
        int cut;
        sum = (cmd == CMD_READ_FW || cmd == CMD_READ_STATUS) ? cmd : cfg_unknown;
        frm.insert(frm.size(), cfg_start);
        frm.insert(frm.size(), 8'(plen + 1));
        frm.insert(frm.size(), cmd);
        repeat (plen) begin
            b = 8'($urandom);
            frm.insert(frm.size(), b);
            sum = sum + b;
        end
        frm.insert(frm.size(), sum);
        frm.insert(frm.size(), cfg_end);
        case (dmg)
            DMG_START: frm[0] ^= 8'($urandom_range(1, 255));
            DMG_END:   frm[frm.size() - 1] ^= 8'($urandom_range(1, 255));
            DMG_SUM:   frm[plen + 3] ^= 8'($urandom_range(1, 255));
            DMG_LEN:   frm[1] = 8'($urandom);
            DMG_CUT:
            begin
                cut = $urandom_range(1, frm.size() - 1);
                frm = frm[0:cut-1];
            end
            DMG_LONG:  repeat ($urandom_range(1, 3)) frm.insert(frm.size(), 8'($urandom));
            default:   ;
        endcase
        foreach (frm[i]) push_byte(frm[i], i == frm.size() - 1);
    endtask

    // Mostly well-formed frames, some damaged, some noise and lone bytes
    task automatic add_random(input int budget, input int lone_pct);
        int stop;
        int r;
        int plen;
        logic [7:0] cmd;
        damage_t dmg;
        stop = queued_items + budget;
        while (queued_items < stop) begin
            r = $urandom_range(0, 99);
            if (r < lone_pct) begin
                push_byte($urandom_range(0, 1) ? cfg_start : 8'($urandom), 1'b1);
            end
            else if (r < lone_pct + 8) begin
                add_noise($urandom_range(2, 12), $urandom_range(0, 1));
            end
            else begin
                plen = ($urandom_range(0, 99) < 3) ? $urandom_range(100, 254)
                                                    : $urandom_range(0, 10);
                r = $urandom_range(0, 9);
                cmd = (r < 4) ? CMD_READ_FW : (r < 7) ? CMD_READ_STATUS : 8'($urandom);
                dmg = ($urandom_range(0, 99) < 65) ? DMG_NONE
                                                   : damage_t'($urandom_range(1, 6));
                add_frame(plen, cmd, dmg);
            end
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [8:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_START_BYTE:   cfg_start   = val[7:0];
            CFG_END_BYTE:     cfg_end     = val[7:0];
            CFG_MIN_FRAME:    cfg_min     = val;
            CFG_UNKNOWN_CODE: cfg_unknown = val[7:0];
            default:          ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Wait until every byte is in and every result is out, then let it settle
    task automatic drain();
        do @(negedge clk);
        while (byte_q.size() != 0 || s_tvalid || frame_results_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [8:0] start_v, input logic [8:0] end_v,
                                 input logic [8:0] min_v, input logic [8:0] unk_v);
        drain();
        write_reg(CFG_START_BYTE, start_v);
        write_reg(CFG_END_BYTE, end_v);
        write_reg(CFG_MIN_FRAME, min_v);
        write_reg(CFG_UNKNOWN_CODE, unk_v);
        @(negedge clk);
    endtask

    initial
    begin
        wait (rst_n);
        @(negedge clk);

        // Directed frames under reset settings
        add_frame(0, CMD_READ_FW, DMG_NONE);
        push_byte(8'h00, 1'b1);
        push_byte(START_BYTE_RST, 1'b0);
        push_byte(8'h03, 1'b0);
        push_byte(CMD_READ_STATUS, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'(CMD_READ_STATUS + 8'hFF), 1'b0);
        push_byte(END_BYTE_RST, 1'b1);
        // zero length with an unknown command
        push_byte(START_BYTE_RST, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(END_BYTE_RST, 1'b1);
        // last byte falls inside the payload
        push_byte(START_BYTE_RST, 1'b0);
        push_byte(8'h05, 1'b0);
        push_byte(CMD_READ_FW, 1'b0);
        push_byte(8'hAA, 1'b0);
        push_byte(8'hBB, 1'b1);
        add_random(150, 3);

        // Bit 8 set on an 8-bit register, minimum frame size of four bytes
        apply_setting(9'h100, 9'h0FF, 9'd4, 9'h000);
        add_random(180, 3);

        // Minimum of 259, the longest frame: only a full-length frame passes
        apply_setting(9'h0FF, 9'h000, 9'd259, 9'h051);
        add_frame(254, CMD_READ_FW, DMG_NONE);
        add_random(100, 3);

        // Minimum of zero, start equal to end, many one-byte frames
        apply_setting(9'h07E, 9'h07E, 9'd0, 9'h0A5);
        add_random(150, 25);

        // Back to reset values; an overlong frame saturates the position
        apply_setting(9'h002, 9'h003, 9'd5, 9'h0FF);
        add_noise(520, 1'b1);
        add_random(60, 3);

        drain();
        repeat (16) @(posedge clk);
        $display("tb: %0d bytes in 5 register settings, %0d payload items, %0d frame statuses",
                 bytes_taken, payload_seen, frames_seen);
        $display("tb: verdicts ok %0d short %0d start %0d end %0d size %0d checksum %0d",
                 verdict_hits[0], verdict_hits[1], verdict_hits[2],
                 verdict_hits[3], verdict_hits[4], verdict_hits[5]);
        if (errors == 0 && frame_results_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ----- stx_etx_frame_checker.f -----
+incdir+design
design/sefc_pkg.sv
design/sefc_front.sv
design/sefc_queue.sv
design/sefc_back.sv
design/stx_etx_frame_checker.sv
tb/sv/tb.sv
